FILE: design/cuct_pkg.sv
package cuct_pkg;

    localparam int unsigned CountWidth = 30;
    localparam int unsigned DipWidth   = 4;
    localparam int unsigned BankWidth  = 2;
    localparam int unsigned ChrWidth   = 5;

    // bit positions in the character bank register
    localparam int unsigned BitStop     = 4;
    localparam int unsigned BitDelegate = 3;

    // counter bits that take part in the time-up match
    localparam int unsigned MatchTop  = 29;
    localparam int unsigned MatchBase = 25;

    localparam logic [DipWidth-1:0] DipReset = 4'd2;

    typedef enum logic {
        CMD_TICK      = 1'b0,
        CMD_CHR_WRITE = 1'b1
    } cuct_cmd_t;

    typedef enum logic [1:0] {
        PH_LOCKED   = 2'd0,
        PH_ARMED    = 2'd1,
        PH_UNLOCKED = 2'd2
    } cuct_phase_t;

    typedef struct packed {
        logic                command;
        logic [ChrWidth-1:0] chr_bank_value;
    } cuct_in_t;

    typedef struct packed {
        logic                 irq_asserted;
        logic                 prg_from_standard_logic;
        logic [BankWidth-1:0] prg_bank32;
        logic                 counter_running;
        logic                 time_up;
    } cuct_out_t;

    // one request as seen by the state blocks
    typedef struct packed {
        logic step;      // request leaves the input register this cycle
        logic chr_write; // request is a register write
        logic stop;      // bit 4 of the written value
        logic delegate;  // bit 3 of the written value
        logic [BankWidth-1:0] bank; // bits 2..1 of the written value
    } cuct_req_t;

    typedef struct packed {
        logic                 delegated;
        logic [BankWidth-1:0] bank;
    } cuct_bank_t;

    typedef struct packed {
        logic irq;
        logic running;
        logic time_up;
    } cuct_timer_t;

endpackage

FILE: design/cuct_unlock.sv
module cuct_unlock
    import cuct_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cuct_req_t  req,
    output logic       unlocked,   // phase before this request
    output cuct_bank_t bank_next   // bank view after this request
);

    cuct_phase_t phase_reg, phase_next;
    cuct_bank_t  bank_reg;
    logic        wr;

    assign wr = req.step && req.chr_write;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LOCKED;
            bank_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            bank_reg  <= bank_next;
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (wr) begin
            unique case (phase_reg)
                PH_LOCKED: begin
                    if (req.stop) phase_next = PH_ARMED;
                end
                PH_ARMED: begin
                    if (!req.stop) phase_next = PH_UNLOCKED;
                end
                PH_UNLOCKED: begin
                    phase_next = PH_UNLOCKED;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // outputs; the unused fourth code counts as unlocked
    always_comb begin
        unlocked  = (phase_reg != PH_LOCKED) && (phase_reg != PH_ARMED);
        bank_next = bank_reg;
        if (wr) begin
            if (!unlocked) begin
                bank_next = '0;
            end else if (req.delegate) begin
                bank_next.delegated = 1'b1;
                bank_next.bank      = '0;
            end else begin
                bank_next.delegated = 1'b0;
                bank_next.bank      = req.bank;
            end
        end
    end

endmodule

FILE: design/cuct_timer.sv
module cuct_timer
    import cuct_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cuct_req_t           req,
    input  logic                unlocked,
    input  logic [DipWidth-1:0] dips,
    output cuct_timer_t         timer_next
);

    logic [CountWidth-1:0] count_reg, count_next;
    logic [CountWidth-1:0] count_inc;
    logic                  enable_reg, enable_next;
    logic                  irq_reg, irq_next;
    logic                  match;
    logic                  up;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            enable_reg <= 1'b0;
            irq_reg    <= 1'b0;
        end else begin
            count_reg  <= count_next;
            enable_reg <= enable_next;
            irq_reg    <= irq_next;
        end
    end

    assign count_inc = count_reg + CountWidth'(1);

    // bit 29 plus every switched-in bit of 25..28
    assign match = count_inc[MatchTop]
                && (&(count_inc[MatchBase +: DipWidth] | ~dips));

    always_comb begin
        count_next  = count_reg;
        enable_next = enable_reg;
        irq_next    = irq_reg;
        up          = 1'b0;
        if (req.step) begin
            if (req.chr_write) begin
                if (unlocked) begin
                    if (req.stop) begin
                        count_next  = '0;
                        enable_next = 1'b0;
                        irq_next    = 1'b0;
                    end else begin
                        enable_next = 1'b1;
                    end
                end
            end else if (enable_reg) begin
                count_next = count_inc;
                if (match) begin
                    irq_next    = 1'b1;
                    enable_next = 1'b0;
                    up          = 1'b1;
                end
            end
        end
    end

    assign timer_next.irq     = irq_next;
    assign timer_next.running = enable_next;
    assign timer_next.time_up = up;

endmodule

FILE: design/cartridge_unlock_and_countdown_timer_core.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   cuct_in_t  (command, chr_bank_value)
// m_        out        m_valid / m_ready   cuct_out_t (irq, banking, counter, time_up)
// dip_wr_   in         dip_wr_en           dip_wr_data, 4 timer-length switches
//
// One request per clock sustained while m_ready is high; m_valid rises as the result
// register loads. The combinational state update between the two registers sets the rate.
// aresetn is synchronous, active low: clears both stage valids, the unlock phase,
// bank view, counter, enable, IRQ and sets the switches to their default.
// A stalled output holds its result; the input register still drains into it
// when m_ready frees the slot, so s_ready only drops while both stages are full.
module cartridge_unlock_and_countdown_timer_core
    import cuct_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                dip_wr_en,
    input  logic [DipWidth-1:0] dip_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  cuct_in_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cuct_out_t           m_data
);

    // input register
    logic      in_valid_reg;
    cuct_in_t  in_data_reg;

    // result register
    logic      out_valid_reg;
    cuct_out_t out_data_reg;

    logic [DipWidth-1:0] dip_reg;

    logic        advance;
    cuct_req_t   req;
    logic        unlocked;
    cuct_bank_t  bank_next;
    cuct_timer_t timer_next;

    // request moves on when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dip_reg       <= DipReset;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (dip_wr_en) begin
                dip_reg <= dip_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg.irq_asserted            <= timer_next.irq;
            out_data_reg.prg_from_standard_logic <= bank_next.delegated;
            out_data_reg.prg_bank32              <= bank_next.delegated ? '0 : bank_next.bank;
            out_data_reg.counter_running         <= timer_next.running;
            out_data_reg.time_up                 <= timer_next.time_up;
        end
    end

    // decode the held request
    assign req.step      = advance;
    assign req.chr_write = (in_data_reg.command == CMD_CHR_WRITE);
    assign req.stop      = in_data_reg.chr_bank_value[BitStop];
    assign req.delegate  = in_data_reg.chr_bank_value[BitDelegate];
    assign req.bank      = in_data_reg.chr_bank_value[1 +: BankWidth];

    cuct_unlock u_unlock (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .unlocked  (unlocked),
        .bank_next (bank_next)
    );

    cuct_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .unlocked   (unlocked),
        .dips       (dip_reg),
        .timer_next (timer_next)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: design/cuct_checker.sv
module cuct_checker
    import cuct_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                dip_wr_en,
    input logic [DipWidth-1:0] dip_wr_data,
    input logic                s_valid,
    input logic                s_ready,
    input cuct_in_t            s_data,
    input logic                m_valid,
    input logic                m_ready,
    input cuct_out_t           m_data
);

    // nothing left over from before reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending straight after reset");

    // time-up raises the IRQ and stops the counter in the same result
    a_time_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.time_up |-> m_data.irq_asserted && !m_data.counter_running)
        else $error("time_up without IRQ or with counter running");

    // delegated banking shows bank 0
    a_delegate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.prg_from_standard_logic |-> m_data.prg_bank32 == '0)
        else $error("bank shown while delegated");

    // a stalled result is held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind cartridge_unlock_and_countdown_timer_core cuct_checker u_cuct_checker (.*);
